>>> rtl/dilp_pkg.sv
// Shared types and constants of the decimal integer line parser.
package dilp_pkg;

    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;
    localparam int VALUE_W = 32;
    localparam int USED_W  = 4;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_char;   // apply a non-terminator character
        logic start_fold;  // a terminator was taken, clear the accumulator
        logic fold_step;   // fold one stored digit into the accumulator
        logic finish;      // load the result register and clear the line state
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_term;     // the offered character is CR or LF
        logic fold_done;   // every stored digit has been folded
        logic out_free;    // the result register can take a new result
    } status_t;

endpackage

>>> rtl/dilp_char_if.sv
// Stream interface that carries one received character per transfer.
interface dilp_char_if;
    logic                          valid;
    logic                          ready;
    logic [dilp_pkg::CHAR_W-1:0]   received_char;

    modport source (output valid, output received_char, input ready);
    modport sink   (input valid, input received_char, output ready);
endinterface

>>> rtl/dilp_result_if.sv
// Stream interface that carries one parsed line value per transfer.
interface dilp_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [dilp_pkg::VALUE_W-1:0]  parsed_value;
    logic [dilp_pkg::USED_W-1:0]          digits_used;

    modport source (output valid, output parsed_value, output digits_used, input ready);
    modport sink   (input valid, input parsed_value, input digits_used, output ready);
endinterface

>>> rtl/dilp_ctrl.sv
// Controller state machine of the decimal integer line parser.
module dilp_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  dilp_pkg::status_t   status,
    output logic                in_ready,
    output dilp_pkg::cmd_t      cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_FOLD = 1'b1;

    logic state_reg;
    logic state_next;
    logic take;

    assign in_ready = (state_reg == S_IDLE);
    assign take     = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd.load_char  = 1'b0;
        cmd.start_fold = 1'b0;
        cmd.fold_step  = 1'b0;
        cmd.finish     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (status.is_term)
                    begin
                        cmd.start_fold = 1'b1;
                        state_next     = S_FOLD;
                    end
                    else
                    begin
                        cmd.load_char = 1'b1;
                    end
                end
            end
            S_FOLD:
            begin
                if (!status.fold_done)
                begin
                    cmd.fold_step = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/dilp_datapath.sv
// Datapath of the decimal integer line parser: digit store, accumulator and result register.
module dilp_datapath
#(
    parameter int DIGIT_SLOTS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [dilp_pkg::CHAR_W-1:0]          received_char,
    input  dilp_pkg::cmd_t                       cmd,
    output dilp_pkg::status_t                    status,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic signed [dilp_pkg::VALUE_W-1:0]  parsed_value,
    output logic [dilp_pkg::USED_W-1:0]          digits_used
);

    localparam int DEPTH = DIGIT_SLOTS - 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DIGIT_SLOTS);
    localparam logic [CW-1:0] COUNT_MAX = CW'(DEPTH);

    logic [dilp_pkg::DIGIT_W-1:0] store_reg [DEPTH];
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic                         neg_reg;
    logic                         neg_next;
    logic [CW-1:0]                k_reg;
    logic [CW-1:0]                k_next;
    logic [dilp_pkg::VALUE_W-1:0] acc_reg;
    logic [dilp_pkg::VALUE_W-1:0] acc_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [dilp_pkg::VALUE_W-1:0] value_reg;
    logic [dilp_pkg::USED_W-1:0]  used_reg;

    logic                         is_digit;
    logic                         store_write;
    logic [dilp_pkg::DIGIT_W-1:0] fold_digit;

    assign is_digit = (received_char >= dilp_pkg::CH_ZERO) &&
                      (received_char <= dilp_pkg::CH_NINE);

    assign status.is_term   = (received_char == dilp_pkg::CH_CR) ||
                              (received_char == dilp_pkg::CH_LF);
    assign status.fold_done = (k_reg == count_reg);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign store_write = cmd.load_char && is_digit && (count_reg < COUNT_MAX);
    assign fold_digit  = store_reg[k_reg[AW-1:0]];

    always_comb
    begin
        count_next = count_reg;
        neg_next   = neg_reg;
        if (cmd.load_char)
        begin
            if (received_char == dilp_pkg::CH_BS && count_reg != '0)
            begin
                count_next = count_reg - 1'b1;
            end
            else if (received_char == dilp_pkg::CH_MINUS && count_reg == '0)
            begin
                neg_next = 1'b1;
            end
            else if (store_write)
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (cmd.finish)
        begin
            count_next = '0;
            neg_next   = 1'b0;
        end
    end

    // acc * 10 is formed as (acc << 3) + (acc << 1); everything wraps at 32 bits.
    always_comb
    begin
        acc_next = acc_reg;
        k_next   = k_reg;
        if (cmd.start_fold)
        begin
            acc_next = '0;
            k_next   = '0;
        end
        else if (cmd.fold_step)
        begin
            acc_next = (acc_reg << 3) + (acc_reg << 1) +
                       dilp_pkg::VALUE_W'(fold_digit);
            k_next   = k_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            neg_reg       <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            neg_reg       <= neg_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (store_write)
        begin
            store_reg[count_reg[AW-1:0]] <= received_char[dilp_pkg::DIGIT_W-1:0];
        end
        if (cmd.finish)
        begin
            value_reg <= neg_reg ? (32'd0 - acc_reg) : acc_reg;
            used_reg  <= dilp_pkg::USED_W'(count_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign parsed_value = value_reg;
    assign digits_used  = used_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("digit count exceeds the store depth");

    a_fold_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fold_step |-> (k_reg < count_reg))
        else $error("fold step past the last stored digit");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (count_reg == '0) && !neg_reg && out_valid_reg)
        else $error("finish did not clear the line and present a result");

endmodule

>>> rtl/decimal_integer_line_parser.sv
// A terminator moves the controller into its fold state; the result register is loaded and
// presented once every stored digit is folded and the output register is free. Any other
// character is taken every cycle; a terminator blocks the input while the shared multiply-add
// folds the stored digits, one per cycle, and longer while an earlier result is still pending.
// A finished result waits in an output register, so characters keep flowing while it is pending.
// Reset (rst_n, asynchronous, active low) empties the line: no digits, no sign, no result.
module decimal_integer_line_parser
#(
    parameter int DIGIT_SLOTS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    dilp_char_if.sink            rx,
    dilp_result_if.source        result
);

    // The controller decides what each cycle does; the datapath holds the digits, the
    // sign, the fold accumulator and the result register. The digit store itself is
    // not cleared by reset; only entries written since the last line are read.
    dilp_pkg::cmd_t    cmd;
    dilp_pkg::status_t status;
    logic              in_ready;

    dilp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    dilp_datapath
    #(
        .DIGIT_SLOTS (DIGIT_SLOTS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .received_char (rx.received_char),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .parsed_value  (result.parsed_value),
        .digits_used   (result.digits_used)
    );

    // The input takes a transfer whenever no fold is in progress.
    assign rx.ready = in_ready;

endmodule
